>>> rtl/stream_substring_replace_core_defines.svh
// Assertion macros for the substring replace core.
`ifndef STREAM_SUBSTRING_REPLACE_CORE_DEFINES_SVH
`define STREAM_SUBSTRING_REPLACE_CORE_DEFINES_SVH

`ifndef NO_ASSERTIONS
// Checked outside reset.
`define SSR_ASSERT(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("ssr assertion failed");
// Checked on every edge, reset included.
`define SSR_ASSERT_ALWAYS(name, clk, prop) \
  name: assert property (@(posedge clk) prop) else $error("ssr assertion failed");
`else
`define SSR_ASSERT(name, clk, rst_n, prop)
`define SSR_ASSERT_ALWAYS(name, clk, prop)
`endif

`endif

>>> rtl/ssr_pkg.sv
package ssr_pkg;

  localparam int unsigned MAX_PATTERN = 8;
  localparam int unsigned MAX_REPLACE = 8;
  localparam int unsigned LEN_W       = 4;
  localparam int unsigned CFG_W       = 64;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned REC_BYTES   = 8;
  localparam int unsigned REC_CNT_W   = 4;
  localparam int unsigned REC_IDX_W   = $clog2(REC_BYTES);
  localparam int unsigned QUEUE_DEPTH = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PATTERN_LEN   = 2'd0,
    CFG_PATTERN_BYTES = 2'd1,
    CFG_REPLACE_LEN   = 2'd2,
    CFG_REPLACE_BYTES = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic [LEN_W-1:0] plen;
    logic [CFG_W-1:0] pbytes;
    logic [LEN_W-1:0] rlen;
    logic [CFG_W-1:0] rbytes;
  } cfg_t;

  // One queued action: cnt bytes of data to send, last marks end of text.
  // cnt == 0 with last set stands for an end-only marker.
  typedef struct packed {
    logic                   last;
    logic [REC_CNT_W-1:0]   cnt;
    logic [8*REC_BYTES-1:0] data;
  } rec_t;

endpackage

>>> rtl/stream_substring_replace_core.sv
// Streaming find-and-replace. Text comes in one byte per transaction (push/full),
// with in_last_i on the final byte; every leftmost, non-overlapping match of the
// pattern is replaced, and results leave one byte per transaction (empty/pop).
// The front window matcher takes one byte per cycle while full is low and turns
// each byte into at most one queued action of zero to eight result bytes; the
// back end sends one result per cycle, while results are popped, from a two-entry
// action queue. A byte that yields at most one result thus sustains one byte per
// cycle; one that yields more holds the back end while it sends them, and full
// rises once the queue is taken up. Configuration writes are taken at once;
// rewriting pattern_len drops any bytes held in the window.
`include "stream_substring_replace_core_defines.svh"

module stream_substring_replace_core #(
  parameter int unsigned MaxPattern = ssr_pkg::MAX_PATTERN
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [ssr_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [ssr_pkg::CFG_W-1:0]     cfg_data_i,
  input  logic                          push,
  output logic                          full,
  input  logic [7:0]                    in_byte_i,
  input  logic                          in_last_i,
  output logic                          empty,
  input  logic                          pop,
  output logic [7:0]                    out_byte_o,
  output logic                          out_has_byte_o,
  output logic                          out_last_o
);

  ssr_pkg::cfg_t cfg_q;
  logic          plen_wr;
  logic          accept;
  logic          front_push, q_full, q_valid, q_deq;
  ssr_pkg::rec_t front_rec, q_rec;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{plen: ssr_pkg::LEN_W'(1), pbytes: '0, rlen: '0, rbytes: '0};
    end else if (cfg_we_i) begin
      case (ssr_pkg::cfg_idx_e'(cfg_idx_i))
        ssr_pkg::CFG_PATTERN_LEN:   cfg_q.plen   <= cfg_data_i[ssr_pkg::LEN_W-1:0];
        ssr_pkg::CFG_PATTERN_BYTES: cfg_q.pbytes <= cfg_data_i;
        ssr_pkg::CFG_REPLACE_LEN:   cfg_q.rlen   <= cfg_data_i[ssr_pkg::LEN_W-1:0];
        ssr_pkg::CFG_REPLACE_BYTES: cfg_q.rbytes <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign plen_wr = cfg_we_i && (cfg_idx_i == ssr_pkg::CFG_PATTERN_LEN);
  assign full    = q_full;
  assign accept  = push && !full;

  ssr_front #(
    .MaxPattern(MaxPattern)
  ) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg_q),
    .clear_i (plen_wr),
    .valid_i (accept),
    .byte_i  (in_byte_i),
    .last_i  (in_last_i),
    .push_o  (front_push),
    .rec_o   (front_rec)
  );

  ssr_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (front_push),
    .rec_i   (front_rec),
    .full_o  (q_full),
    .valid_o (q_valid),
    .rec_o   (q_rec),
    .pop_i   (q_deq)
  );

  ssr_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .valid_i        (q_valid),
    .rec_i          (q_rec),
    .deq_o          (q_deq),
    .pop_i          (pop),
    .empty_o        (empty),
    .out_byte_o     (out_byte_o),
    .out_has_byte_o (out_has_byte_o),
    .out_last_o     (out_last_o)
  );

  // A result either carries a byte or closes the text.
  `SSR_ASSERT(a_result_meaningful, clk_i, rst_ni, !empty |-> (out_has_byte_o || out_last_o))
  // End-only markers carry a zero byte.
  `SSR_ASSERT(a_marker_zero, clk_i, rst_ni, (!empty && !out_has_byte_o) |-> (out_byte_o == 8'h00))
  // Popping the last held result with nothing queued drains the output.
  `SSR_ASSERT(a_drain, clk_i, rst_ni, (pop && !empty && !q_valid) |=> empty)
  `SSR_ASSERT_ALWAYS(a_reset_empty, clk_i, !rst_ni |-> empty)

endmodule

>>> rtl/ssr_front.sv
module ssr_front #(
  parameter int unsigned MaxPattern = ssr_pkg::MAX_PATTERN
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  ssr_pkg::cfg_t cfg_i,
  input  logic          clear_i,
  input  logic          valid_i,
  input  logic [7:0]    byte_i,
  input  logic          last_i,
  output logic          push_o,
  output ssr_pkg::rec_t rec_o
);

  localparam int unsigned CntW = $clog2(MaxPattern + 1);
  localparam int unsigned LenW = ssr_pkg::LEN_W;

  logic [CntW-1:0] cnt_q, cnt_d, cnt_new;
  logic [7:0]      win_q   [MaxPattern];
  logic [7:0]      win_new [MaxPattern];
  logic [7:0]      win_sh  [MaxPattern];
  logic [LenW-1:0] plen_eff, rlen_eff;
  logic            win_full, hit;

  always_comb begin
    if (cfg_i.plen == '0) begin
      plen_eff = LenW'(1);
    end else if (cfg_i.plen > LenW'(MaxPattern)) begin
      plen_eff = LenW'(MaxPattern);
    end else begin
      plen_eff = cfg_i.plen;
    end
    if (cfg_i.rlen > LenW'(ssr_pkg::MAX_REPLACE)) begin
      rlen_eff = LenW'(ssr_pkg::MAX_REPLACE);
    end else begin
      rlen_eff = cfg_i.rlen;
    end
  end

  assign cnt_new  = cnt_q + 1'b1;
  assign win_full = (LenW'(cnt_new) == plen_eff);

  // New byte lands at the current fill position.
  always_comb begin
    for (int i = 0; i < MaxPattern; i++) begin
      win_new[i] = (CntW'(i) == cnt_q) ? byte_i : win_q[i];
    end
    for (int i = 0; i < MaxPattern - 1; i++) begin
      win_sh[i] = win_new[i+1];
    end
    win_sh[MaxPattern-1] = win_new[MaxPattern-1];
  end

  always_comb begin
    hit = 1'b1;
    for (int i = 0; i < MaxPattern; i++) begin
      if ((LenW'(i) < plen_eff) && (win_new[i] != cfg_i.pbytes[8*i +: 8])) begin
        hit = 1'b0;
      end
    end
  end

  always_comb begin
    rec_o      = '0;
    rec_o.last = last_i;
    if (win_full && hit) begin
      rec_o.data = cfg_i.rbytes;
      rec_o.cnt  = rlen_eff;
    end else begin
      for (int i = 0; i < MaxPattern; i++) begin
        rec_o.data[8*i +: 8] = win_new[i];
      end
      // On a miss with a full window the oldest byte goes out; on the final byte the whole window does.
      if (last_i) begin
        rec_o.cnt = ssr_pkg::REC_CNT_W'(cnt_new);
      end else if (win_full) begin
        rec_o.cnt = ssr_pkg::REC_CNT_W'(1);
      end
    end
  end

  assign push_o = valid_i && ((rec_o.cnt != '0) || last_i);

  always_comb begin
    cnt_d = cnt_q;
    if (clear_i) begin
      cnt_d = '0;
    end else if (valid_i) begin
      if ((win_full && hit) || last_i) begin
        cnt_d = '0;
      end else if (win_full) begin
        cnt_d = cnt_q;
      end else begin
        cnt_d = cnt_new;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i) begin
      win_q <= win_full ? win_sh : win_new;
    end
  end

endmodule

>>> rtl/ssr_fifo.sv
module ssr_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  ssr_pkg::rec_t rec_i,
  output logic          full_o,
  output logic          valid_o,
  output ssr_pkg::rec_t rec_o,
  input  logic          pop_i
);

  localparam int unsigned Depth = ssr_pkg::QUEUE_DEPTH;
  localparam int unsigned PtrW  = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW  = $clog2(Depth + 1);

  ssr_pkg::rec_t   mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign valid_o = (cnt_q != '0);
  assign rec_o   = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
    return (p == PtrW'(Depth - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= ptr_inc(wr_ptr_q);
      end
      if (do_pop) begin
        rd_ptr_q <= ptr_inc(rd_ptr_q);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= rec_i;
    end
  end

endmodule

>>> rtl/ssr_back.sv
module ssr_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          valid_i,
  input  ssr_pkg::rec_t rec_i,
  output logic          deq_o,
  input  logic          pop_i,
  output logic          empty_o,
  output logic [7:0]    out_byte_o,
  output logic          out_has_byte_o,
  output logic          out_last_o
);

  localparam int unsigned CntW = ssr_pkg::REC_CNT_W;

  logic                           out_valid_q;
  logic [ssr_pkg::REC_IDX_W-1:0]  idx_q;
  logic                           load, take, is_end, marker;
  logic [7:0]                     byte_q;
  logic                           has_q, last_q;

  assign load    = !out_valid_q || pop_i;
  assign take    = load && valid_i;
  assign marker  = (rec_i.cnt == '0);
  assign is_end  = marker || ((CntW'(idx_q) + 1'b1) == rec_i.cnt);
  assign deq_o   = take && is_end;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      idx_q       <= '0;
    end else begin
      if (load) begin
        out_valid_q <= valid_i;
      end
      if (take) begin
        idx_q <= is_end ? '0 : idx_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      byte_q <= marker ? 8'h00 : rec_i.data[8*idx_q +: 8];
      has_q  <= !marker;
      last_q <= rec_i.last && is_end;
    end
  end

  assign empty_o        = !out_valid_q;
  assign out_byte_o     = byte_q;
  assign out_has_byte_o = has_q;
  assign out_last_o     = last_q;

endmodule
